@@ rtl/nlc_pkg.sv @@
package nlc_pkg;

	// Result classes
	localparam logic [2:0] CLS_REJECTED   = 3'd0;
	localparam logic [2:0] CLS_POS_INT    = 3'd1;
	localparam logic [2:0] CLS_POS_FLOAT  = 3'd2;
	localparam logic [2:0] CLS_UNDEF_FRAC = 3'd3;
	localparam logic [2:0] CLS_FRAC       = 3'd4;
	localparam logic [2:0] CLS_NEG_INT    = 3'd5;
	localparam logic [2:0] CLS_NEG_FLOAT  = 3'd6;

	// Character codes the recognizer reacts to
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_POINT = 8'h2E;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	// One character step handed to the recognizer
	typedef struct packed {
		logic [7:0] char_code;
		logic       last;
	} step_t;

endpackage

@@ rtl/numeric_literal_classifier_core.sv @@
// A string's class reaches m_tvalid via the input register and then the result register.
// Throughput: one character word per cycle; the recognizer state register closes a
// loop, and the input stage stalls only while a finished class waits on m_tready.
// Reset: arst_n clears the recognizer to its start state and drops both valid flags.
module numeric_literal_classifier_core (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] char_code
	input  logic       s_tlast,   // end_of_string
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata    // [2:0] literal_class, [7:3] zero
);

	logic           valid_s1;
	nlc_pkg::step_t step_s1;
	logic           out_free;
	logic           adv_s1;
	logic [2:0]     class_next;
	logic           m_valid_q;
	logic [2:0]     class_q;

	// Handshake between stages
	assign out_free = !m_valid_q || m_tready;
	assign adv_s1   = valid_s1 && (!step_s1.last || out_free);
	assign s_tready = !valid_s1 || adv_s1;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			step_s1.char_code <= s_tdata;
			step_s1.last      <= s_tlast;
		end
	end

	nlc_recognizer u_recognizer (
		.clk           (clk),
		.arst_n        (arst_n),
		.step_en       (adv_s1),
		.step          (step_s1),
		.literal_class (class_next)
	);

	// Result register: load a class only for the last character of a string
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_free) begin
			m_valid_q <= valid_s1 && step_s1.last;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && valid_s1 && step_s1.last) begin
			class_q <= class_next;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {5'b0, class_q};

endmodule

@@ rtl/nlc_recognizer.sv @@
module nlc_recognizer (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step_en,
	input  nlc_pkg::step_t     step,
	output logic [2:0]         literal_class
);

	localparam logic [3:0] ST_START      = 4'd0;
	localparam logic [3:0] ST_PLUS       = 4'd1;
	localparam logic [3:0] ST_POS_INT    = 4'd2;
	localparam logic [3:0] ST_POS_POINT  = 4'd3;
	localparam logic [3:0] ST_POS_FLOAT  = 4'd4;
	localparam logic [3:0] ST_SLASH      = 4'd5;
	localparam logic [3:0] ST_DEN_SIGN   = 4'd6;
	localparam logic [3:0] ST_UNDEF_FRAC = 4'd7;
	localparam logic [3:0] ST_FRAC       = 4'd8;
	localparam logic [3:0] ST_MINUS      = 4'd9;
	localparam logic [3:0] ST_NEG_INT    = 4'd10;
	localparam logic [3:0] ST_NEG_POINT  = 4'd11;
	localparam logic [3:0] ST_NEG_FLOAT  = 4'd12;
	localparam logic [3:0] ST_ERROR      = 4'd13;

	logic [3:0] state_q;
	logic [3:0] state_next;
	logic       is_digit;
	logic       is_zero;
	logic       is_plus;
	logic       is_minus;
	logic       is_point;
	logic       is_slash;

	// Decode the character
	always_comb begin
		is_digit = (step.char_code >= nlc_pkg::CH_ZERO) && (step.char_code <= nlc_pkg::CH_NINE);
		is_zero  = (step.char_code == nlc_pkg::CH_ZERO);
		is_plus  = (step.char_code == nlc_pkg::CH_PLUS);
		is_minus = (step.char_code == nlc_pkg::CH_MINUS);
		is_point = (step.char_code == nlc_pkg::CH_POINT);
		is_slash = (step.char_code == nlc_pkg::CH_SLASH);
	end

	// Next state; anything unexpected drops into the sticky error state
	always_comb begin
		state_next = ST_ERROR;
		case (state_q)
			ST_START: begin
				if (is_digit)      state_next = ST_POS_INT;
				else if (is_plus)  state_next = ST_PLUS;
				else if (is_minus) state_next = ST_MINUS;
				else if (is_point) state_next = ST_POS_POINT;
			end
			ST_PLUS: begin
				if (is_digit)      state_next = ST_POS_INT;
				else if (is_point) state_next = ST_POS_POINT;
			end
			ST_POS_INT: begin
				if (is_digit)      state_next = ST_POS_INT;
				else if (is_slash) state_next = ST_SLASH;
				else if (is_point) state_next = ST_POS_POINT;
			end
			ST_POS_POINT, ST_POS_FLOAT: begin
				if (is_digit) state_next = ST_POS_FLOAT;
			end
			ST_SLASH: begin
				if (is_plus || is_minus) state_next = ST_DEN_SIGN;
				else if (is_zero)        state_next = ST_UNDEF_FRAC;
				else if (is_digit)       state_next = ST_FRAC;
			end
			ST_DEN_SIGN, ST_UNDEF_FRAC: begin
				if (is_zero)       state_next = ST_UNDEF_FRAC;
				else if (is_digit) state_next = ST_FRAC;
			end
			ST_FRAC: begin
				if (is_digit) state_next = ST_FRAC;
			end
			ST_MINUS: begin
				if (is_digit)      state_next = ST_NEG_INT;
				else if (is_point) state_next = ST_NEG_POINT;
			end
			ST_NEG_INT: begin
				if (is_digit)      state_next = ST_NEG_INT;
				else if (is_slash) state_next = ST_SLASH;
				else if (is_point) state_next = ST_NEG_POINT;
			end
			ST_NEG_POINT, ST_NEG_FLOAT: begin
				if (is_digit) state_next = ST_NEG_FLOAT;
			end
			default: state_next = ST_ERROR;
		endcase
	end

	// Class of the state reached after this character
	always_comb begin
		case (state_next)
			ST_POS_INT:    literal_class = nlc_pkg::CLS_POS_INT;
			ST_POS_FLOAT:  literal_class = nlc_pkg::CLS_POS_FLOAT;
			ST_UNDEF_FRAC: literal_class = nlc_pkg::CLS_UNDEF_FRAC;
			ST_FRAC:       literal_class = nlc_pkg::CLS_FRAC;
			ST_NEG_INT:    literal_class = nlc_pkg::CLS_NEG_INT;
			ST_NEG_FLOAT:  literal_class = nlc_pkg::CLS_NEG_FLOAT;
			default:       literal_class = nlc_pkg::CLS_REJECTED;
		endcase
	end

	// Advance, or restart after the last character of a string
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_START;
		end else if (step_en) begin
			state_q <= step.last ? ST_START : state_next;
		end
	end

endmodule

@@ rtl/nlc_checker.sv @@
module nlc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       s_tvalid,
	input logic       s_tready,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata
);

	// Hold a stalled result word
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result word changed while stalled");

	// Stall input only behind a blocked result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && !m_tready)
		else $error("input stalled without a blocked result");

	// Keep padding bits clear
	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[7:3] == 5'd0)
		else $error("result padding not zero");

	// Emit only defined class codes
	a_class_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[2:0] <= nlc_pkg::CLS_NEG_FLOAT)
		else $error("result class out of range");

endmodule

bind numeric_literal_classifier_core nlc_checker u_nlc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
